// ===== sv/angle_color_ramp_interpolator_macros.svh =====
// assertion macros for the angle colour ramp interpolator
`ifndef ANGLE_COLOR_RAMP_INTERPOLATOR_MACROS_SVH
`define ANGLE_COLOR_RAMP_INTERPOLATOR_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, sampled on clock, off during reset
`define ACRI_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acri assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define ACRI_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acri assertion failed");

`else

`define ACRI_ASSERT_IMPLY(label, ante, cons)
`define ACRI_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== sv/acri_pkg.sv =====
// shared constants and types for the angle colour ramp interpolator
`default_nettype none

package acri_pkg;

   localparam int MAX_ANGLES = 8;
   localparam int ANGLE_W    = 16;
   localparam int CH_W       = 8;
   localparam int IDX_W      = 4;
   localparam int AIDX_W     = $clog2(MAX_ANGLES);
   localparam int W_W        = ANGLE_W + 1;
   localparam int PROD_W     = (CH_W + 1) + (W_W + 1);

   // long division: quotient bits resolved per pipeline stage
   localparam int DIV_STEPS  = 2;
   localparam int DIV_STAGES = ANGLE_W / DIV_STEPS;

   // edges from the accepting edge to the edge that takes the result
   localparam int RSP_LATENCY = DIV_STAGES + 5;

   localparam logic [IDX_W-1:0] MAX_IDX = IDX_W'(MAX_ANGLES);

   localparam logic KIND_WRITE = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   localparam int   CSR_ADDR_W          = 3;
   localparam int   CSR_DATA_W          = 32;
   localparam logic CSR_SEL_ANGLE_COUNT = 1'b0;

   typedef struct packed {
      logic [CH_W-1:0] red;
      logic [CH_W-1:0] green;
      logic [CH_W-1:0] blue;
   } rgb_type;

   // travels alongside the divider
   typedef struct packed {
      logic [IDX_W-1:0] seg;
      rgb_type          c1;
      rgb_type          c2;
      logic             force_zero;
      logic             force_one;
   } side_type;

endpackage

`default_nettype wire

// ===== sv/angle_color_ramp_interpolator.sv =====
// top level: piecewise linear colour ramp over angle with pipelined interpolation
//
// A transaction is accepted at a rising edge with start high and busy low; busy
// is always low, so one transaction may be accepted at every edge. A write
// transaction (kind 0) loads one angle and colour entry of the table; at entry
// index eight only the colour is loaded, above eight nothing happens. A query
// transaction (kind 1) gives theta and yields one result: the blended colour
// and the segment found. Writes yield no result.
// A query passes through stages a, b and c, the divider stages, m and r; its result
// is on the rsp_ ports with rsp_valid high.
// Throughput is one transaction per cycle; the depth is set by the 16-bit
// weight division, two quotient bits per stage over eight stages.
// A write followed by a query at the next edge is seen by that query.
// angle_count is set over the apb-style port at byte address 0 and must only
// be written while no query is in flight. Reset clears angle_count and all
// valid bits in flight; table contents are undefined until written.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

`include "angle_color_ramp_interpolator_macros.svh"

module angle_color_ramp_interpolator
   import acri_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // command channel
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic                  req_kind,
   input  wire logic [IDX_W-1:0]      req_entry_index,
   input  wire logic [ANGLE_W-1:0]    req_entry_angle,
   input  wire logic [CH_W-1:0]       req_entry_red,
   input  wire logic [CH_W-1:0]       req_entry_green,
   input  wire logic [CH_W-1:0]       req_entry_blue,
   input  wire logic [ANGLE_W-1:0]    req_theta,
   // result channel
   output logic                       rsp_valid,
   output logic [CH_W-1:0]            rsp_out_red,
   output logic [CH_W-1:0]            rsp_out_green,
   output logic [CH_W-1:0]            rsp_out_blue,
   output logic [IDX_W-1:0]           rsp_segment,
   // register port
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0]      prdata,
   output logic                       pready
);

   // register port
   logic [IDX_W-1:0] angle_count_ff;
   logic             csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready &&
                      (paddr[2] == CSR_SEL_ANGLE_COUNT);

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_count_ff <= '0;
      end else if (csr_write) begin
         angle_count_ff <= pwdata[IDX_W-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == CSR_SEL_ANGLE_COUNT) begin
         prdata = CSR_DATA_W'(angle_count_ff);
      end
   end

   assign busy = 1'b0;

   // tables
   logic [ANGLE_W-1:0] angle_table [MAX_ANGLES];
   rgb_type            color_table [MAX_ANGLES+1];

   // stage a: registered transaction
   logic               a_valid_ff;
   logic               a_valid_in;
   logic               a_kind_ff;
   logic [IDX_W-1:0]   a_index_ff;
   logic [ANGLE_W-1:0] a_angle_ff;
   rgb_type            a_rgb_ff;
   logic [ANGLE_W-1:0] a_theta_ff;

   assign a_valid_in = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      a_kind_ff  <= req_kind;
      a_index_ff <= req_entry_index;
      a_angle_ff <= req_entry_angle;
      a_rgb_ff   <= '{red: req_entry_red, green: req_entry_green, blue: req_entry_blue};
      a_theta_ff <= req_theta;
   end

   // table writes land at the end of stage a, after every earlier query has read
   always_ff @(posedge clock) begin
      if (a_valid_ff && (a_kind_ff == KIND_WRITE)) begin
         if (a_index_ff < MAX_IDX) begin
            angle_table[a_index_ff[AIDX_W-1:0]] <= a_angle_ff;
            color_table[a_index_ff]             <= a_rgb_ff;
         end else if (a_index_ff == MAX_IDX) begin
            color_table[a_index_ff] <= a_rgb_ff;
         end
      end
   end

   // stage a: parallel compares and first-match search
   logic [IDX_W-1:0]  count_used;
   logic [MAX_ANGLES-1:0] hit;
   logic              a_found;
   logic [AIDX_W-1:0] a_first;
   logic              b_valid_in;
   logic [IDX_W-1:0]  b_seg_in;

   assign count_used = (angle_count_ff > MAX_IDX) ? MAX_IDX : angle_count_ff;

   always_comb begin
      for (int i = 0; i < MAX_ANGLES; i++) begin
         hit[i] = (IDX_W'(i) < count_used) && (a_theta_ff <= angle_table[i]);
      end
   end

   always_comb begin
      a_found = 1'b0;
      a_first = '0;
      for (int i = MAX_ANGLES - 1; i >= 0; i--) begin
         if (hit[i]) begin
            a_found = 1'b1;
            a_first = AIDX_W'(i);
         end
      end
   end

   assign b_valid_in = a_valid_ff && (a_kind_ff == KIND_QUERY);
   assign b_seg_in   = a_found ? IDX_W'(a_first) : count_used;

   // stage b: fetch segment ends and colours
   logic               b_valid_ff;
   logic [IDX_W-1:0]   b_seg_ff;
   logic               b_found_ff;
   logic [ANGLE_W-1:0] b_theta_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else begin
         b_valid_ff <= b_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      b_seg_ff   <= b_seg_in;
      b_found_ff <= a_found;
      b_theta_ff <= a_theta_ff;
   end

   logic [IDX_W-1:0]   seg_prev;
   logic [IDX_W-1:0]   seg_upper;
   logic [ANGLE_W-1:0] hi_angle;
   logic [ANGLE_W-1:0] lo_angle;
   logic [ANGLE_W-1:0] c_num_in;
   logic [ANGLE_W-1:0] c_den_in;
   side_type           c_side_in;

   assign seg_prev  = b_seg_ff - IDX_W'(1);
   assign seg_upper = b_found_ff ? (b_seg_ff + IDX_W'(1)) : b_seg_ff;
   assign hi_angle  = angle_table[b_seg_ff[AIDX_W-1:0]];
   assign lo_angle  = (b_seg_ff == '0) ? '0 : angle_table[seg_prev[AIDX_W-1:0]];
   assign c_num_in  = b_theta_ff - lo_angle;
   assign c_den_in  = hi_angle - lo_angle;

   always_comb begin
      c_side_in.seg        = b_seg_ff;
      c_side_in.c1         = color_table[b_seg_ff];
      c_side_in.c2         = color_table[seg_upper];
      // past the last angle, or an empty segment: plain colour, weight zero
      c_side_in.force_zero = !b_found_ff || (c_den_in == '0);
      c_side_in.force_one  = b_found_ff && (c_den_in != '0) && (c_num_in == c_den_in);
   end

   // stage c: divider operands
   logic               c_valid_ff;
   logic [ANGLE_W-1:0] c_num_ff;
   logic [ANGLE_W-1:0] c_den_ff;
   side_type           c_side_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else begin
         c_valid_ff <= b_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      c_num_ff  <= c_num_in;
      c_den_ff  <= c_den_in;
      c_side_ff <= c_side_in;
   end

   logic           d_valid;
   logic [W_W-1:0] d_weight;
   side_type       d_side;

   acri_div_pipe u_div (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (c_valid_ff),
      .in_num     (c_num_ff),
      .in_den     (c_den_ff),
      .in_side    (c_side_ff),
      .out_valid  (d_valid),
      .out_weight (d_weight),
      .out_side   (d_side)
   );

   // stage m: (c2 - c1) * w per channel
   logic                     m_valid_ff;
   logic signed [PROD_W-1:0] m_prod_red_ff;
   logic signed [PROD_W-1:0] m_prod_green_ff;
   logic signed [PROD_W-1:0] m_prod_blue_ff;
   rgb_type                  m_c1_ff;
   logic [IDX_W-1:0]         m_seg_ff;
   logic signed [PROD_W-1:0] m_prod_red_in;
   logic signed [PROD_W-1:0] m_prod_green_in;
   logic signed [PROD_W-1:0] m_prod_blue_in;
   logic signed [W_W:0]      weight_s;

   assign weight_s = $signed({1'b0, d_weight});

   function automatic logic signed [CH_W:0] chan_diff(input logic [CH_W-1:0] c1,
                                                      input logic [CH_W-1:0] c2);
      return $signed({1'b0, c2}) - $signed({1'b0, c1});
   endfunction

   assign m_prod_red_in   = PROD_W'(chan_diff(d_side.c1.red, d_side.c2.red)) *
                            PROD_W'(weight_s);
   assign m_prod_green_in = PROD_W'(chan_diff(d_side.c1.green, d_side.c2.green)) *
                            PROD_W'(weight_s);
   assign m_prod_blue_in  = PROD_W'(chan_diff(d_side.c1.blue, d_side.c2.blue)) *
                            PROD_W'(weight_s);

   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else begin
         m_valid_ff <= d_valid;
      end
   end

   always_ff @(posedge clock) begin
      m_prod_red_ff   <= m_prod_red_in;
      m_prod_green_ff <= m_prod_green_in;
      m_prod_blue_ff  <= m_prod_blue_in;
      m_c1_ff         <= d_side.c1;
      m_seg_ff        <= d_side.seg;
   end

   // stage r: c1 * 65536 + product, rounded to nearest
   function automatic logic [CH_W-1:0] blend_round(input logic [CH_W-1:0]          c1,
                                                   input logic signed [PROD_W-1:0] prod);
      logic signed [PROD_W-1:0] acc;
      acc = $signed({{(PROD_W-CH_W-ANGLE_W){1'b0}}, c1, {ANGLE_W{1'b0}}}) + prod +
            $signed(PROD_W'(1 << (ANGLE_W - 1)));
      return acc[ANGLE_W+CH_W-1:ANGLE_W];
   endfunction

   logic             rsp_valid_ff;
   logic [CH_W-1:0]  rsp_red_ff;
   logic [CH_W-1:0]  rsp_green_ff;
   logic [CH_W-1:0]  rsp_blue_ff;
   logic [IDX_W-1:0] rsp_seg_ff;
   logic [CH_W-1:0]  rsp_red_in;
   logic [CH_W-1:0]  rsp_green_in;
   logic [CH_W-1:0]  rsp_blue_in;

   assign rsp_red_in   = blend_round(m_c1_ff.red,   m_prod_red_ff);
   assign rsp_green_in = blend_round(m_c1_ff.green, m_prod_green_ff);
   assign rsp_blue_in  = blend_round(m_c1_ff.blue,  m_prod_blue_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= m_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_red_ff   <= rsp_red_in;
      rsp_green_ff <= rsp_green_in;
      rsp_blue_ff  <= rsp_blue_in;
      rsp_seg_ff   <= m_seg_ff;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_segment   = rsp_seg_ff;

   // checks
   `ACRI_ASSERT_IMPLY(a_rsp_from_query, rsp_valid,
      $past(start && !busy && (req_kind == KIND_QUERY), RSP_LATENCY))
   `ACRI_ASSERT_IMPLY(a_segment_in_range, rsp_valid, rsp_segment <= MAX_IDX)
   `ACRI_ASSERT_NEXT(a_count_written, csr_write,
      angle_count_ff == $past(pwdata[IDX_W-1:0]))

endmodule

`default_nettype wire

// ===== sv/acri_div_pipe.sv =====
// pipelined restoring divider producing the q1.16 blend weight
`default_nettype none

module acri_div_pipe
   import acri_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               in_valid,
   input  wire logic [ANGLE_W-1:0] in_num,
   input  wire logic [ANGLE_W-1:0] in_den,
   input  wire side_type           in_side,
   output logic                    out_valid,
   output logic [W_W-1:0]          out_weight,
   output side_type                out_side
);

   logic               valid_ff [DIV_STAGES];
   logic [ANGLE_W-1:0] quo_ff   [DIV_STAGES];
   logic [ANGLE_W-1:0] den_ff   [DIV_STAGES];
   side_type           side_ff  [DIV_STAGES];
   logic [ANGLE_W-1:0] rem_ff   [DIV_STAGES-1];

   for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
      logic               st_valid;
      logic [ANGLE_W-1:0] st_rem;
      logic [ANGLE_W-1:0] st_quo;
      logic [ANGLE_W-1:0] st_den;
      side_type           st_side;
      logic [ANGLE_W-1:0] rem_in;
      logic [ANGLE_W-1:0] quo_in;

      if (s == 0) begin : g_first
         // the numerator is used as the starting remainder; when it equals the divisor, force_one sets the weight
         assign st_valid = in_valid;
         assign st_rem   = in_num;
         assign st_quo   = '0;
         assign st_den   = in_den;
         assign st_side  = in_side;
      end else begin : g_next
         assign st_valid = valid_ff[s-1];
         assign st_rem   = rem_ff[s-1];
         assign st_quo   = quo_ff[s-1];
         assign st_den   = den_ff[s-1];
         assign st_side  = side_ff[s-1];
      end

      always_comb begin
         logic [ANGLE_W:0]   r2;
         logic [ANGLE_W-1:0] r;
         logic [ANGLE_W-1:0] q;
         logic [ANGLE_W-1:0] half;
         // low dividend bits are the rounding term den/2
         half = st_den >> 1;
         r    = st_rem;
         q    = st_quo;
         for (int j = 0; j < DIV_STEPS; j++) begin
            r2 = {r, half[ANGLE_W-1-s*DIV_STEPS-j]};
            if (r2 >= {1'b0, st_den}) begin
               r = ANGLE_W'(r2 - {1'b0, st_den});
               q[ANGLE_W-1-s*DIV_STEPS-j] = 1'b1;
            end else begin
               r = r2[ANGLE_W-1:0];
            end
         end
         rem_in = r;
         quo_in = q;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else begin
            valid_ff[s] <= st_valid;
         end
      end

      always_ff @(posedge clock) begin
         quo_ff[s]  <= quo_in;
         den_ff[s]  <= st_den;
         side_ff[s] <= st_side;
      end

      if (s < DIV_STAGES - 1) begin : g_rem
         always_ff @(posedge clock) begin
            rem_ff[s] <= rem_in;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_side  = side_ff[DIV_STAGES-1];

   always_comb begin
      if (side_ff[DIV_STAGES-1].force_zero) begin
         out_weight = '0;
      end else if (side_ff[DIV_STAGES-1].force_one) begin
         out_weight = {1'b1, {ANGLE_W{1'b0}}};
      end else begin
         out_weight = {1'b0, quo_ff[DIV_STAGES-1]};
      end
   end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// self-checking testbench for the angle colour ramp interpolator
`timescale 1ns / 100ps

module testbench
   import acri_pkg::*;
();

   localparam int CYCLE_LIMIT = 200000;
   localparam int DRAIN_CYCLES = RSP_LATENCY + 4;
   localparam logic [CSR_ADDR_W-1:0] ADDR_ANGLE_COUNT = CSR_ADDR_W'(0);
   localparam logic [CSR_ADDR_W-1:0] ADDR_UNMAPPED = CSR_ADDR_W'(4);

   typedef struct {
      logic             kind;
      logic [IDX_W-1:0] index;
      logic [ANGLE_W-1:0] angle;
      rgb_type          colour;
      logic [ANGLE_W-1:0] theta;
   } ramp_cmd_type;

   typedef struct {
      rgb_type          colour;
      logic [IDX_W-1:0] seg;
   } ramp_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic req_kind = KIND_WRITE;
   logic [IDX_W-1:0] req_entry_index = '0;
   logic [ANGLE_W-1:0] req_entry_angle = '0;
   logic [CH_W-1:0] req_entry_red = '0;
   logic [CH_W-1:0] req_entry_green = '0;
   logic [CH_W-1:0] req_entry_blue = '0;
   logic [ANGLE_W-1:0] req_theta = '0;
   logic rsp_valid;
   logic [CH_W-1:0] rsp_out_red;
   logic [CH_W-1:0] rsp_out_green;
   logic [CH_W-1:0] rsp_out_blue;
   logic [IDX_W-1:0] rsp_segment;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] paddr = '0;
   logic [CSR_DATA_W-1:0] pwdata = '0;
   logic [CSR_DATA_W-1:0] prdata;
   logic pready;

   // predictor state
   logic [ANGLE_W-1:0] angle_tab [MAX_ANGLES];
   rgb_type colour_tab [MAX_ANGLES+1];
   logic [IDX_W-1:0] count_reg = '0;

   // generator's view of the angle table, used to aim theta at breakpoints
   int unsigned gen_angles [MAX_ANGLES];

   ramp_cmd_type pending_cmds [$];
   ramp_rsp_type expected_colours [$];
   ramp_cmd_type driven_cmd;
   ramp_rsp_type exp_rsp;
   int idle_pct = 0;
   int fail_count = 0;
   int cycle_count = 0;

   angle_color_ramp_interpolator i_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_kind        (req_kind),
      .req_entry_index (req_entry_index),
      .req_entry_angle (req_entry_angle),
      .req_entry_red   (req_entry_red),
      .req_entry_green (req_entry_green),
      .req_entry_blue  (req_entry_blue),
      .req_theta       (req_theta),
      .rsp_valid       (rsp_valid),
      .rsp_out_red     (rsp_out_red),
      .rsp_out_green   (rsp_out_green),
      .rsp_out_blue    (rsp_out_blue),
      .rsp_segment     (rsp_segment),
      .psel            (psel),
      .penable         (penable),
      .pwrite          (pwrite),
      .paddr           (paddr),
      .pwdata          (pwdata),
      .prdata          (prdata),
      .pready          (pready)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   function automatic logic [CH_W-1:0] blend_channel(input logic [CH_W-1:0] c1,
                                                     input logic [CH_W-1:0] c2,
                                                     input longint unsigned w);
      longint unsigned acc;
      acc = longint'(c1) * (65536 - w) + longint'(c2) * w + 32768;
      return CH_W'(acc >> 16);
   endfunction

   // updates the table copy for writes, queues the blended colour for queries
   task automatic predict_ramp_colour(input ramp_cmd_type c);
      int unsigned n;
      int unsigned seg;
      int unsigned lo;
      int unsigned hi;
      int unsigned d;
      longint unsigned w;
      rgb_type c1;
      rgb_type c2;
      ramp_rsp_type r;
      if (c.kind == KIND_WRITE) begin
         if (c.index < MAX_ANGLES) begin
            angle_tab[c.index] = c.angle;
            colour_tab[c.index] = c.colour;
         end else if (c.index == MAX_IDX) begin
            colour_tab[MAX_ANGLES] = c.colour;
         end
      end else begin
         n = (count_reg > MAX_ANGLES) ? MAX_ANGLES : count_reg;
         seg = n;
         for (int k = 0; k < n; k++) begin
            if (seg == n && c.theta <= angle_tab[k]) seg = k;
         end
         if (seg == n) begin
            r.colour = colour_tab[n];
         end else begin
            hi = angle_tab[seg];
            lo = (seg == 0) ? 0 : angle_tab[seg-1];
            d = hi - lo;
            if (d == 0) w = 0;
            else w = ((longint'(c.theta - lo) << 16) + (d >> 1)) / d;
            if (w > 65536) w = 65536;
            c1 = colour_tab[seg];
            c2 = colour_tab[seg+1];
            r.colour.red = blend_channel(c1.red, c2.red, w);
            r.colour.green = blend_channel(c1.green, c2.green, w);
            r.colour.blue = blend_channel(c1.blue, c2.blue, w);
         end
         r.seg = IDX_W'(seg);
         expected_colours.insert(expected_colours.size(), r);
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) predict_ramp_colour(driven_cmd);
         if (start && busy) begin
            // hold the transaction until it is taken
         end else if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
            driven_cmd = pending_cmds.pop_front();
            start <= 1'b1;
            req_kind <= driven_cmd.kind;
            req_entry_index <= driven_cmd.index;
            req_entry_angle <= driven_cmd.angle;
            req_entry_red <= driven_cmd.colour.red;
            req_entry_green <= driven_cmd.colour.green;
            req_entry_blue <= driven_cmd.colour.blue;
            req_theta <= driven_cmd.theta;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_colours.size() == 0) begin
            $error("result with no query outstanding");
            fail_count++;
         end else begin
            exp_rsp = expected_colours.pop_front();
            if (rsp_out_red !== exp_rsp.colour.red) begin
               $error("out_red: expected %0d, actual %0d", exp_rsp.colour.red, rsp_out_red);
               fail_count++;
            end
            if (rsp_out_green !== exp_rsp.colour.green) begin
               $error("out_green: expected %0d, actual %0d", exp_rsp.colour.green,
                      rsp_out_green);
               fail_count++;
            end
            if (rsp_out_blue !== exp_rsp.colour.blue) begin
               $error("out_blue: expected %0d, actual %0d", exp_rsp.colour.blue,
                      rsp_out_blue);
               fail_count++;
            end
            if (rsp_segment !== exp_rsp.seg) begin
               $error("segment: expected %0d, actual %0d", exp_rsp.seg, rsp_segment);
               fail_count++;
            end
         end
      end
   end

   task automatic push_write(input int unsigned idx, input int unsigned ang,
                             input logic [23:0] rgb);
      ramp_cmd_type c;
      c.kind = KIND_WRITE;
      c.index = IDX_W'(idx);
      c.angle = ANGLE_W'(ang);
      c.colour = rgb;
      c.theta = ANGLE_W'($urandom());
      if (idx < MAX_ANGLES) gen_angles[idx] = ang & 16'hFFFF;
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   task automatic push_query(input int unsigned th);
      ramp_cmd_type c;
      c.kind = KIND_QUERY;
      c.index = IDX_W'($urandom());
      c.angle = ANGLE_W'($urandom());
      c.colour = 24'($urandom());
      c.theta = ANGLE_W'(th);
      pending_cmds.insert(pending_cmds.size(), c);
   endtask

   // sorted random breakpoints, sometimes packed into a narrow span to get ties
   task automatic load_rising_table();
      int unsigned vals [MAX_ANGLES];
      int unsigned span;
      int unsigned tmp;
      span = $urandom_range(1) ? 65535 : $urandom_range(40, 1);
      for (int k = 0; k < MAX_ANGLES; k++) vals[k] = $urandom_range(span, 0);
      for (int k = 1; k < MAX_ANGLES; k++) begin
         for (int j = k; j > 0 && vals[j-1] > vals[j]; j--) begin
            tmp = vals[j];
            vals[j] = vals[j-1];
            vals[j-1] = tmp;
         end
      end
      for (int k = 0; k <= MAX_ANGLES; k++) begin
         push_write(k, (k < MAX_ANGLES) ? vals[k] : $urandom(), 24'($urandom()));
      end
   endtask

   task automatic push_random_cmd();
      int unsigned idx;
      int unsigned k;
      int unsigned lo;
      int unsigned hi;
      if ($urandom_range(99) < 20) begin
         idx = $urandom_range(15, 0);
         if (idx < MAX_ANGLES && $urandom_range(1)) begin
            // keep the table rising around this entry
            lo = (idx == 0) ? 0 : gen_angles[idx-1];
            hi = (idx == MAX_ANGLES-1) ? 65535 : gen_angles[idx+1];
            push_write(idx, $urandom_range(hi, lo), 24'($urandom()));
         end else begin
            push_write(idx, $urandom() & 16'hFFFF, 24'($urandom()));
         end
      end else begin
         k = $urandom_range(MAX_ANGLES-1, 0);
         case ($urandom_range(2))
            0: push_query($urandom() & 16'hFFFF);
            1: push_query((gen_angles[k] + $urandom_range(2, 0) - 1) & 16'hFFFF);
            default: begin
               lo = (k == 0) ? 0 : gen_angles[k-1];
               push_query($urandom_range(gen_angles[k], lo));
            end
         endcase
      end
   endtask

   // waits until every transaction is taken and every result has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_cmds.size() != 0 || start || expected_colours.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_W-1:0] addr, input logic [31:0] data);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock);
      while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == ADDR_ANGLE_COUNT) count_reg = data[IDX_W-1:0];
   endtask

   task automatic check_count();
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b0;
      paddr <= ADDR_ANGLE_COUNT;
      @(posedge clock);
      penable <= 1'b1;
      @(negedge clock);
      while (!pready) @(negedge clock);
      if (prdata[IDX_W-1:0] !== count_reg) begin
         $error("angle_count: expected %0d, actual %0d", count_reg, prdata[IDX_W-1:0]);
         fail_count++;
      end
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("Verification failed");
      $finish;
   end

   initial begin
      int unsigned phase_count [6];
      int phase_idle [6];
      phase_count = '{0, 15, 1, 8, 3, 4};
      phase_idle = '{88, 22, 0, 88, 22, 0};
      phase_count[4] = $urandom_range(15, 0);
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      check_count();
      csr_write(ADDR_ANGLE_COUNT, 32'(MAX_ANGLES));
      check_count();

      // directed: extremes, equal breakpoints, ignored writes, non-rising table
      idle_pct = 0;
      push_write(0, 0, 24'h000000);
      push_write(1, 1000, 24'hFFFFFF);
      push_write(2, 1000, 24'hFF0080);
      push_write(3, 8000, 24'h00FF7F);
      push_write(4, 20000, 24'h0000FF);
      push_write(5, 40000, 24'h807F01);
      push_write(6, 60000, 24'hFE01FF);
      push_write(7, 65535, 24'h123456);
      push_write(MAX_ANGLES, 65535, 24'h112233);
      push_write(9, 12345, 24'hABCDEF);
      push_write(15, 65535, 24'hFFFFFF);
      push_query(0);
      push_query(1);
      push_query(500);
      push_query(1000);
      push_query(1001);
      push_query(4500);
      push_query(8000);
      push_query(30000);
      push_query(65534);
      push_query(65535);
      push_write(3, 500, 24'h55AA55);
      push_query(1500);
      wait_idle();

      for (int p = 0; p < 6; p++) begin
         if (p == 2) begin
            // unmapped register address must leave angle_count alone
            csr_write(ADDR_UNMAPPED, $urandom());
            check_count();
         end
         csr_write(ADDR_ANGLE_COUNT, {$urandom_range(1) ? 28'($urandom()) : 28'h0,
                                      phase_count[p][IDX_W-1:0]});
         check_count();
         idle_pct = phase_idle[p];
         load_rising_table();
         repeat (176) push_random_cmd();
         wait_idle();
      end

      if (fail_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/acri_pkg.sv
sv/acri_div_pipe.sv
sv/angle_color_ramp_interpolator.sv
tb/sv/testbench.sv
